// ===== hdl/vpd_pkg.sv =====
`default_nettype none
package vpd_pkg;

    // field widths
    localparam int POS_W       = 16;
    localparam int VEL_W       = 21;
    localparam int DRIVE_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int ERR_W       = 22;
    localparam int DERR_W      = 23;
    localparam int INTEG_W     = 25;
    localparam int ILIM_W      = 24;
    localparam int OLIM_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // velocity scaling: steps per sample window to steps per second
    localparam int VEL_SCALE_NUM = 1000;
    localparam int VEL_FRAC_BITS = 26;
    localparam int VEL_SCALE_W   = 36;

    // gains are Q8.8
    localparam int GAIN_FRAC_BITS = 8;

    // velocity saturation bounds
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VELOCITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT    = 3'd5;

    // register reset values
    localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RST = 24'd65535;
    localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RST   = 15'd1000;

    // controller settings handed to the loop
    typedef struct packed {
        logic signed [GAIN_W-1:0] target_velocity;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [ILIM_W-1:0] integral_limit;
        logic        [OLIM_W-1:0] output_limit;
    } t_pid_cfg;

endpackage
`default_nettype wire

// ===== hdl/vpd_velocity.sv =====
`default_nettype none
module vpd_velocity #(
    parameter int HISTORY_DEPTH    = 10,
    parameter int SAMPLE_PERIOD_MS = 100
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic        [vpd_pkg::POS_W-1:0]       i_position_raw,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed      [vpd_pkg::VEL_W-1:0]       o_velocity
);

    localparam int PosW   = vpd_pkg::POS_W;
    localparam int VelW   = vpd_pkg::VEL_W;
    localparam int ScaleW = vpd_pkg::VEL_SCALE_W;
    localparam int FracB  = vpd_pkg::VEL_FRAC_BITS;
    localparam int ProdW  = ScaleW + PosW;
    localparam int QW     = ProdW - FracB;
    localparam int TapN   = HISTORY_DEPTH - 1;

    // ceil(1000 * 2^26 / period): exact truncating divide for 16-bit magnitudes
    localparam logic [ScaleW-1:0] VelScale = ScaleW'(
        ((64'(vpd_pkg::VEL_SCALE_NUM) << FracB) + 64'(SAMPLE_PERIOD_MS) - 64'd1)
        / 64'(SAMPLE_PERIOD_MS));
    localparam logic [QW-1:0] VelMaxMag = QW'((64'd1 << (VelW - 1)) - 64'd1);
    localparam logic [QW-1:0] VelMinMag = QW'(64'd1 << (VelW - 1));

    logic [PosW-1:0]          r_hist [TapN];
    logic                     r_a_vld;
    logic                     r_a_neg;
    logic [PosW-1:0]          r_a_mag;
    logic                     r_b_vld;
    logic signed [VelW-1:0]   r_b_vel;

    logic                     ld_a;
    logic                     ld_b;
    logic                     accept;
    logic [PosW:0]            n_diff;
    logic [PosW-1:0]          n_mag;
    logic [ProdW-1:0]         prod;
    logic [QW-1:0]            quot;
    logic signed [VelW-1:0]   n_vel;

    // stage loads
    assign ld_b    = !r_b_vld || i_ready;
    assign ld_a    = !r_a_vld || ld_b;
    assign o_ready = ld_a;
    assign accept  = i_valid && ld_a;

    // new sample minus the oldest one in the window
    assign n_diff = {1'b0, i_position_raw} - {1'b0, r_hist[TapN-1]};
    assign n_mag  = PosW'(n_diff[PosW] ? -n_diff : n_diff);

    // history window, newest at tap zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TapN; i++) begin
                r_hist[i] <= '0;
            end
        end else if (accept) begin
            r_hist[0] <= i_position_raw;
            for (int i = 1; i < TapN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // stage a: sign and magnitude of the difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (ld_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_neg <= n_diff[PosW];
            r_a_mag <= n_mag;
        end
    end

    // scale by reciprocal and saturate
    assign prod = ProdW'(r_a_mag) * ProdW'(VelScale);
    assign quot = prod[FracB +: QW];

    always_comb begin
        if (!r_a_neg) begin
            n_vel = (quot > VelMaxMag) ? vpd_pkg::VEL_MAX : VelW'(quot);
        end else begin
            n_vel = (quot > VelMinMag) ? vpd_pkg::VEL_MIN
                                       : VelW'(-$signed({1'b0, quot}));
        end
    end

    // stage b: velocity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (ld_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_b && r_a_vld) begin
            r_b_vel <= n_vel;
        end
    end

    assign o_valid    = r_b_vld;
    assign o_velocity = r_b_vel;

endmodule
`default_nettype wire

// ===== hdl/vpd_pid.sv =====
`default_nettype none
module vpd_pid (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vpd_pkg::t_pid_cfg                  i_cfg,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [vpd_pkg::VEL_W-1:0]   i_velocity,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [vpd_pkg::DRIVE_W-1:0]      o_drive_value,
    output logic signed [vpd_pkg::VEL_W-1:0]        o_velocity
);

    localparam int VelW   = vpd_pkg::VEL_W;
    localparam int ErrW   = vpd_pkg::ERR_W;
    localparam int DerrW  = vpd_pkg::DERR_W;
    localparam int IntW   = vpd_pkg::INTEG_W;
    localparam int IsumW  = IntW + 1;
    localparam int GainW  = vpd_pkg::GAIN_W;
    localparam int DrvW   = vpd_pkg::DRIVE_W;
    localparam int GFrac  = vpd_pkg::GAIN_FRAC_BITS;
    localparam int PpW    = GainW + ErrW;
    localparam int PiW    = GainW + IntW;
    localparam int PdW    = GainW + DerrW;
    localparam int SumW   = PiW + 2;
    localparam int ShW    = SumW - GFrac;

    // loop state
    logic signed [ErrW-1:0]   r_prev_err;
    logic signed [IntW-1:0]   r_integ;

    // pipeline registers
    logic                     r_c_vld;
    logic signed [ErrW-1:0]   r_c_err;
    logic signed [DerrW-1:0]  r_c_derr;
    logic signed [VelW-1:0]   r_c_vel;
    logic                     r_d_vld;
    logic signed [ErrW-1:0]   r_d_err;
    logic signed [DerrW-1:0]  r_d_derr;
    logic signed [VelW-1:0]   r_d_vel;
    logic                     r_e_vld;
    logic signed [PpW-1:0]    r_e_pp;
    logic signed [PiW-1:0]    r_e_pi;
    logic signed [PdW-1:0]    r_e_pd;
    logic signed [VelW-1:0]   r_e_vel;
    logic                     r_f_vld;
    logic signed [DrvW-1:0]   r_f_drive;
    logic signed [VelW-1:0]   r_f_vel;

    logic                     ld_c;
    logic                     ld_d;
    logic                     ld_e;
    logic                     ld_f;
    logic signed [ErrW-1:0]   n_err;
    logic signed [DerrW-1:0]  n_derr;
    logic signed [IsumW-1:0]  isum;
    logic signed [IsumW-1:0]  ilim_pos;
    logic signed [IsumW-1:0]  ilim_neg;
    logic signed [IntW-1:0]   n_integ;
    logic signed [SumW-1:0]   sum;
    logic signed [SumW-1:0]   sum_adj;
    logic signed [ShW-1:0]    scaled;
    logic signed [ShW-1:0]    olim_pos;
    logic signed [ShW-1:0]    olim_neg;
    logic signed [DrvW-1:0]   n_drive;

    // stage loads
    assign ld_f    = !r_f_vld || i_ready;
    assign ld_e    = !r_e_vld || ld_f;
    assign ld_d    = !r_d_vld || ld_e;
    assign ld_c    = !r_c_vld || ld_d;
    assign o_ready = ld_c;

    // error and its change since the previous sample
    assign n_err  = ErrW'(i_cfg.target_velocity) - ErrW'(i_velocity);
    assign n_derr = DerrW'(n_err) - DerrW'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld    <= 1'b0;
            r_prev_err <= '0;
        end else if (ld_c) begin
            r_c_vld <= i_valid;
            if (i_valid) begin
                r_prev_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_c && i_valid) begin
            r_c_err  <= n_err;
            r_c_derr <= n_derr;
            r_c_vel  <= i_velocity;
        end
    end

    // integral with symmetric saturation
    assign isum     = IsumW'(r_integ) + IsumW'(r_c_err);
    assign ilim_pos = $signed({2'b00, i_cfg.integral_limit});
    assign ilim_neg = -ilim_pos;

    always_comb begin
        if (isum > ilim_pos) begin
            n_integ = IntW'(ilim_pos);
        end else if (isum < ilim_neg) begin
            n_integ = IntW'(ilim_neg);
        end else begin
            n_integ = IntW'(isum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_integ <= '0;
        end else if (ld_d) begin
            r_d_vld <= r_c_vld;
            if (r_c_vld) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_d && r_c_vld) begin
            r_d_err  <= r_c_err;
            r_d_derr <= r_c_derr;
            r_d_vel  <= r_c_vel;
        end
    end

    // three gain products in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (ld_e) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_e && r_d_vld) begin
            r_e_pp  <= PpW'(i_cfg.gain_p) * PpW'(r_d_err);
            r_e_pi  <= PiW'(i_cfg.gain_i) * PiW'(r_integ);
            r_e_pd  <= PdW'(i_cfg.gain_d) * PdW'(r_d_derr);
            r_e_vel <= r_d_vel;
        end
    end

    // sum, drop the fraction toward zero, clamp
    assign sum      = SumW'(r_e_pp) + SumW'(r_e_pi) + SumW'(r_e_pd);
    assign sum_adj  = sum[SumW-1] ? sum + SumW'((1 << GFrac) - 1) : sum;
    assign scaled   = ShW'(sum_adj >>> GFrac);
    assign olim_pos = $signed(ShW'(i_cfg.output_limit));
    assign olim_neg = -olim_pos;

    always_comb begin
        if (scaled > olim_pos) begin
            n_drive = DrvW'(olim_pos);
        end else if (scaled < olim_neg) begin
            n_drive = DrvW'(olim_neg);
        end else begin
            n_drive = DrvW'(scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (ld_f) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_f && r_e_vld) begin
            r_f_drive <= n_drive;
            r_f_vel   <= r_e_vel;
        end
    end

    assign o_valid       = r_f_vld;
    assign o_drive_value = r_f_drive;
    assign o_velocity    = r_f_vel;

endmodule
`default_nettype wire

// ===== hdl/velocity_pid_drive_unit.sv =====
// Velocity PID drive: one raw position sample in, one drive command and one
// velocity estimate out, one request per clock cycle sustained while the
// output is not stalled. A request is a six-stage pipeline: difference
// against the oldest sample of the history window, reciprocal-multiply
// scaling to steps per second with saturation, error against the set point,
// saturated integral update, three parallel gain multiplies, then the Q8.8
// fraction drop and output clamp. Each stage holds one register, the first
// loaded at the edge that accepts the input, and the result is valid once it
// reaches the sixth; output stalls hold it there. The history window is
// cleared by reset, so the first samples see zeros as the oldest position.
// Stages hold their contents under output stall and the input keeps taking
// requests as long as any stage is empty. Configuration is written through
// its own port, which is always ready; write only while the block is idle.
`default_nettype none
module velocity_pid_drive_unit #(
    parameter int HISTORY_DEPTH    = 10,
    parameter int SAMPLE_PERIOD_MS = 100
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write port
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [vpd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [vpd_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // position samples
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [vpd_pkg::POS_W-1:0]              i_position_raw,
    // drive results
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [vpd_pkg::DRIVE_W-1:0]          o_drive_value,
    output logic signed [vpd_pkg::VEL_W-1:0]            o_velocity_estimate
);

    vpd_pkg::t_pid_cfg                  r_cfg;
    logic                               vel_ready;
    logic                               vel_valid;
    logic signed [vpd_pkg::VEL_W-1:0]   vel_value;
    logic                               pid_ready;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_velocity <= '0;
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= '0;
            r_cfg.integral_limit  <= vpd_pkg::INTEGRAL_LIMIT_RST;
            r_cfg.output_limit    <= vpd_pkg::OUTPUT_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                vpd_pkg::CFG_TARGET_VELOCITY: begin
                    r_cfg.target_velocity <= $signed(i_cfg_data[vpd_pkg::GAIN_W-1:0]);
                end
                vpd_pkg::CFG_GAIN_P: begin
                    r_cfg.gain_p <= $signed(i_cfg_data[vpd_pkg::GAIN_W-1:0]);
                end
                vpd_pkg::CFG_GAIN_I: begin
                    r_cfg.gain_i <= $signed(i_cfg_data[vpd_pkg::GAIN_W-1:0]);
                end
                vpd_pkg::CFG_GAIN_D: begin
                    r_cfg.gain_d <= $signed(i_cfg_data[vpd_pkg::GAIN_W-1:0]);
                end
                vpd_pkg::CFG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data[vpd_pkg::ILIM_W-1:0];
                end
                vpd_pkg::CFG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[vpd_pkg::OLIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // velocity estimate front end
    vpd_velocity #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
    ) u_velocity (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (vel_ready),
        .i_position_raw (i_position_raw),
        .o_valid        (vel_valid),
        .i_ready        (pid_ready),
        .o_velocity     (vel_value)
    );

    assign o_in_stall = !vel_ready;

    // pid loop and output register
    vpd_pid u_pid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (vel_valid),
        .o_ready       (pid_ready),
        .i_velocity    (vel_value),
        .o_valid       (o_out_valid),
        .i_ready       (!i_out_stall),
        .o_drive_value (o_drive_value),
        .o_velocity    (o_velocity_estimate)
    );

endmodule
`default_nettype wire

// ===== hdl/vpd_checker.sv =====
`default_nettype none
module vpd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic signed [vpd_pkg::DRIVE_W-1:0]  o_drive_value,
    input wire logic signed [vpd_pkg::VEL_W-1:0]    o_velocity_estimate
);

    localparam logic [3:0] PipeDepth = 4'd6;

    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       in_acc;
    logic       out_acc;

    // requests inside the block
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign n_cnt   = r_cnt + 4'(in_acc) - 4'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a result only for a request taken earlier
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cnt != 4'd0))
        else $error("result shown with no request outstanding");

    // never more requests than pipeline stages
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PipeDepth)
        else $error("more requests held than pipeline stages");

    // an empty output register means the input is open
    a_input_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register empty");

    // result held under stall
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_drive_value) && $stable(o_velocity_estimate)))
        else $error("result payload changed while stalled");

endmodule

bind velocity_pid_drive_unit vpd_checker u_vpd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_drive_value       (o_drive_value),
    .o_velocity_estimate (o_velocity_estimate)
);
`default_nettype wire
